@@ hw/rtl/l1_victim_l2_cache_controller_macros.svh @@
// ---------------------------------------------------------------------------
// Cache controller assertion macros
// Concurrent checks that compile away when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef L1_VICTIM_L2_CACHE_CONTROLLER_MACROS_SVH
`define L1_VICTIM_L2_CACHE_CONTROLLER_MACROS_SVH

`ifndef SYNTH
`define LVC_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("cache controller check failed");
`define LVC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("cache controller check failed");
`else
`define LVC_ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define LVC_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

@@ hw/rtl/lvc_pkg.sv @@
// ---------------------------------------------------------------------------
// Cache controller package
// Sizes, item types and the L2 row layout shared by the controller modules.
// ---------------------------------------------------------------------------
`default_nettype none

package lvc_pkg;

    localparam int L1_SETS        = 16;
    localparam int L2_SETS        = 16;
    localparam int L2_WAYS        = 8;
    localparam int VICTIM_ENTRIES = 4;

    localparam int IDX_W   = $clog2(L1_SETS);
    localparam int WAY_W   = $clog2(L2_WAYS);
    localparam int VIC_W   = $clog2(VICTIM_ENTRIES);
    localparam int IDX_LSB = 2;
    localparam int TAG_LSB = IDX_LSB + IDX_W;

    localparam logic FUNC_READ = 1'b1;

    typedef enum logic [1:0] {
        SRC_L1     = 2'd0,
        SRC_VICTIM = 2'd1,
        SRC_L2     = 2'd2,
        SRC_MEM    = 2'd3
    } src_t;

    typedef struct packed {
        logic               func;
        logic [31:0]        address;
        logic signed [31:0] write_data;
        logic signed [31:0] mem_word;
    } req_t;

    typedef struct packed {
        logic [1:0]         served_from;
        logic signed [31:0] read_data;
        logic [31:0]        l1_accesses;
        logic [31:0]        l1_misses;
        logic [31:0]        victim_accesses;
        logic [31:0]        victim_misses;
        logic [31:0]        l2_accesses;
        logic [31:0]        l2_misses;
    } rsp_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] word;
    } line_t;

    typedef line_t [L2_WAYS-1:0] row_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] set;
        logic [WAY_W-1:0] way;
        line_t            line;
    } l2_wr_t;

    function automatic logic [IDX_W-1:0] idx_of(input logic [31:0] a);
        return a[IDX_LSB +: IDX_W];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lvc_l2_mem.sv @@
// ---------------------------------------------------------------------------
// L2 line store
// One row per set holding address and word of every way; registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module lvc_l2_mem (
    input  wire logic                          clk,
    input  wire logic                          rd_en,
    input  wire logic [lvc_pkg::IDX_W-1:0]     rd_set,
    output lvc_pkg::row_t                      rd_row,
    input  lvc_pkg::l2_wr_t                    wr
);
    import lvc_pkg::*;

    row_t mem [L2_SETS];
    row_t rd_row_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.set][wr.way] <= wr.line;
        end
        if (rd_en)
        begin
            rd_row_reg <= mem[rd_set];
        end
    end

    assign rd_row = rd_row_reg;

endmodule

`default_nettype wire

@@ hw/rtl/lvc_core.sv @@
// ---------------------------------------------------------------------------
// Cache controller core
// L1, victim and L2 tag state, lookup, promotion, eviction chain and counters.
// ---------------------------------------------------------------------------
`default_nettype none

module lvc_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       commit,
    input  lvc_pkg::req_t   req,
    input  lvc_pkg::row_t   row,
    output lvc_pkg::rsp_t   rsp,
    output lvc_pkg::l2_wr_t wr
);
    import lvc_pkg::*;

    localparam int CNT_L1_ACC  = 0;
    localparam int CNT_L1_MISS = 1;
    localparam int CNT_V_ACC   = 2;
    localparam int CNT_V_MISS  = 3;
    localparam int CNT_L2_ACC  = 4;
    localparam int CNT_L2_MISS = 5;
    localparam int CNT_N       = 6;
    localparam logic [VIC_W-1:0] VIC_MAX = VIC_W'(VICTIM_ENTRIES - 1);
    localparam logic [WAY_W-1:0] WAY_MAX = WAY_W'(L2_WAYS - 1);

    logic             l1_valid_reg  [L1_SETS];
    logic             l1_valid_next [L1_SETS];
    line_t            l1_line_reg   [L1_SETS];
    line_t            l1_line_next  [L1_SETS];
    logic             v_valid_reg   [VICTIM_ENTRIES];
    logic             v_valid_next  [VICTIM_ENTRIES];
    line_t            v_line_reg    [VICTIM_ENTRIES];
    line_t            v_line_next   [VICTIM_ENTRIES];
    logic [VIC_W-1:0] v_age_reg     [VICTIM_ENTRIES];
    logic [VIC_W-1:0] v_age_next    [VICTIM_ENTRIES];
    logic             l2_valid_reg  [L2_SETS][L2_WAYS];
    logic             l2_valid_next [L2_SETS][L2_WAYS];
    logic [WAY_W-1:0] l2_age_reg    [L2_SETS][L2_WAYS];
    logic [WAY_W-1:0] l2_age_next   [L2_SETS][L2_WAYS];
    logic [31:0]      cnt_reg       [CNT_N];
    logic [31:0]      cnt_next      [CNT_N];

    logic             is_read;
    logic [IDX_W-1:0] x;
    logic             hit1;
    logic             vhit;
    logic [VIC_W-1:0] vi;
    logic             lhit;
    logic [WAY_W-1:0] lj;
    logic [31:0]      w;
    logic             fill;
    logic [31:0]      fill_word;
    logic             vfound;
    logic [VIC_W-1:0] vv;
    logic             ins_l2;
    line_t            ins_line;
    logic [IDX_W-1:0] s2;
    logic             lfound;
    logic [WAY_W-1:0] lw;
    src_t             served;

    always_comb
    begin
        l1_valid_next = l1_valid_reg;
        l1_line_next  = l1_line_reg;
        v_valid_next  = v_valid_reg;
        v_line_next   = v_line_reg;
        v_age_next    = v_age_reg;
        l2_valid_next = l2_valid_reg;
        l2_age_next   = l2_age_reg;
        cnt_next      = cnt_reg;

        is_read = (req.func == FUNC_READ);
        x       = idx_of(req.address);
        hit1    = l1_valid_reg[x]
                  && (l1_line_reg[x].addr[31:TAG_LSB] == req.address[31:TAG_LSB]);

        vhit = 1'b0;
        vi   = '0;
        for (int i = 0; i < VICTIM_ENTRIES; i++)
        begin
            if (!vhit && v_valid_reg[i] && (v_line_reg[i].addr == req.address))
            begin
                vhit = 1'b1;
                vi   = VIC_W'(i);
            end
        end

        lhit = 1'b0;
        lj   = '0;
        for (int j = 0; j < L2_WAYS; j++)
        begin
            if (!lhit && l2_valid_reg[x][j]
                && (row[j].addr[31:TAG_LSB] == req.address[31:TAG_LSB]))
            begin
                lhit = 1'b1;
                lj   = WAY_W'(j);
            end
        end

        w         = vhit ? v_line_reg[vi].word : (lhit ? row[lj].word : req.mem_word);
        fill      = !hit1 && (is_read || vhit || lhit);
        fill_word = is_read ? w : req.write_data;

        // remove the hit entry first
        if (!hit1 && vhit)
        begin
            for (int k = 0; k < VICTIM_ENTRIES; k++)
            begin
                if (v_age_reg[k] > v_age_reg[vi])
                begin
                    v_age_next[k] = v_age_reg[k] - 1'b1;
                end
            end
            v_age_next[vi]   = VIC_MAX;
            v_valid_next[vi] = 1'b0;
        end
        if (!hit1 && !vhit && lhit)
        begin
            for (int k = 0; k < L2_WAYS; k++)
            begin
                if (l2_age_reg[x][k] > l2_age_reg[x][lj])
                begin
                    l2_age_next[x][k] = l2_age_reg[x][k] - 1'b1;
                end
            end
            l2_age_next[x][lj]   = WAY_MAX;
            l2_valid_next[x][lj] = 1'b0;
        end

        if (!is_read && hit1)
        begin
            l1_line_next[x].addr = req.address;
            l1_line_next[x].word = req.write_data;
        end

        vfound   = 1'b0;
        vv       = '0;
        ins_l2   = 1'b0;
        ins_line = v_line_reg[0];
        if (fill)
        begin
            l1_valid_next[x]     = 1'b1;
            l1_line_next[x].addr = req.address;
            l1_line_next[x].word = fill_word;
            if (l1_valid_reg[x])
            begin
                for (int i = 0; i < VICTIM_ENTRIES; i++)
                begin
                    if (!vfound && (v_age_next[i] == VIC_MAX))
                    begin
                        vfound = 1'b1;
                        vv     = VIC_W'(i);
                    end
                end
                ins_l2   = v_valid_next[vv];
                ins_line = v_line_reg[vv];
                v_valid_next[vv] = 1'b1;
                v_line_next[vv]  = l1_line_reg[x];
                for (int k = 0; k < VICTIM_ENTRIES; k++)
                begin
                    v_age_next[k] = v_age_next[k] + 1'b1;
                end
                v_age_next[vv] = '0;
            end
        end

        s2     = idx_of(ins_line.addr);
        lfound = 1'b0;
        lw     = '0;
        if (ins_l2)
        begin
            for (int j = 0; j < L2_WAYS; j++)
            begin
                if (!lfound && (l2_age_next[s2][j] == WAY_MAX))
                begin
                    lfound = 1'b1;
                    lw     = WAY_W'(j);
                end
            end
            l2_valid_next[s2][lw] = 1'b1;
            for (int k = 0; k < L2_WAYS; k++)
            begin
                l2_age_next[s2][k] = l2_age_next[s2][k] + 1'b1;
            end
            l2_age_next[s2][lw] = '0;
        end

        if (is_read)
        begin
            cnt_next[CNT_L1_ACC] = cnt_reg[CNT_L1_ACC] + 32'd1;
            if (!hit1)
            begin
                cnt_next[CNT_L1_MISS] = cnt_reg[CNT_L1_MISS] + 32'd1;
                cnt_next[CNT_V_ACC]   = cnt_reg[CNT_V_ACC] + 32'd1;
                if (!vhit)
                begin
                    cnt_next[CNT_V_MISS] = cnt_reg[CNT_V_MISS] + 32'd1;
                    cnt_next[CNT_L2_ACC] = cnt_reg[CNT_L2_ACC] + 32'd1;
                    if (!lhit)
                    begin
                        cnt_next[CNT_L2_MISS] = cnt_reg[CNT_L2_MISS] + 32'd1;
                    end
                end
            end
        end

        served = hit1 ? SRC_L1 : (vhit ? SRC_VICTIM : (lhit ? SRC_L2 : SRC_MEM));
    end

    assign rsp.served_from     = served;
    assign rsp.read_data       = is_read ? (hit1 ? l1_line_reg[x].word : w) : req.write_data;
    assign rsp.l1_accesses     = cnt_next[CNT_L1_ACC];
    assign rsp.l1_misses       = cnt_next[CNT_L1_MISS];
    assign rsp.victim_accesses = cnt_next[CNT_V_ACC];
    assign rsp.victim_misses   = cnt_next[CNT_V_MISS];
    assign rsp.l2_accesses     = cnt_next[CNT_L2_ACC];
    assign rsp.l2_misses       = cnt_next[CNT_L2_MISS];

    assign wr.en   = commit && ins_l2;
    assign wr.set  = s2;
    assign wr.way  = lw;
    assign wr.line = ins_line;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < L1_SETS; i++)
            begin
                l1_valid_reg[i] <= 1'b0;
            end
            for (int i = 0; i < VICTIM_ENTRIES; i++)
            begin
                v_valid_reg[i] <= 1'b0;
                v_age_reg[i]   <= VIC_W'(i);
            end
            for (int s = 0; s < L2_SETS; s++)
            begin
                for (int j = 0; j < L2_WAYS; j++)
                begin
                    l2_valid_reg[s][j] <= 1'b0;
                    l2_age_reg[s][j]   <= WAY_W'(j);
                end
            end
            for (int c = 0; c < CNT_N; c++)
            begin
                cnt_reg[c] <= '0;
            end
        end
        else if (commit)
        begin
            l1_valid_reg <= l1_valid_next;
            v_valid_reg  <= v_valid_next;
            v_age_reg    <= v_age_next;
            l2_valid_reg <= l2_valid_next;
            l2_age_reg   <= l2_age_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            l1_line_reg <= l1_line_next;
            v_line_reg  <= v_line_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/l1_victim_l2_cache_controller.sv @@
// ---------------------------------------------------------------------------
// L1 / victim / L2 cache controller
// Exclusive three-level word cache with access statistics per read.
// ---------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------
//  request  | req_valid, req_ready | req  (func, address, data)
//  response | rsp_valid, rsp_ready | rsp  (source, word, counters)
//
//  One item per cycle unless stalled; stage 1, then the response register.
//  The L2 row read of the set is registered at request time; a row write
//  of the item just ahead is forwarded into the lookup.
//  Reset clears all valid bits and counters and sets LRU ages; no clearing pass.
//  A stalled response holds the item in flight and drops req_ready.
// ---------------------------------------------------------------------------
`default_nettype none

`include "l1_victim_l2_cache_controller_macros.svh"

module l1_victim_l2_cache_controller (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  lvc_pkg::req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output lvc_pkg::rsp_t rsp
);
    import lvc_pkg::*;

    logic   s1_valid_reg;
    logic   s1_valid_next;
    req_t   s1_req_reg;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    rsp_t   rsp_reg;
    l2_wr_t fwd_reg;
    l2_wr_t fwd_next;
    logic   advance;
    logic   accept;
    row_t   mem_row;
    row_t   row_fwd;
    rsp_t   core_rsp;
    l2_wr_t core_wr;

    assign advance   = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || advance;
    assign accept    = req_valid && req_ready;

    lvc_l2_mem u_mem (
        .clk    (clk),
        .rd_en  (accept),
        .rd_set (idx_of(req.address)),
        .rd_row (mem_row),
        .wr     (core_wr)
    );

    always_comb
    begin
        row_fwd = mem_row;
        if (fwd_reg.en && (fwd_reg.set == idx_of(s1_req_reg.address)))
        begin
            row_fwd[fwd_reg.way] = fwd_reg.line;
        end
    end

    lvc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (advance),
        .req    (s1_req_reg),
        .row    (row_fwd),
        .rsp    (core_rsp),
        .wr     (core_wr)
    );

    always_comb
    begin
        s1_valid_next  = accept || (s1_valid_reg && !advance);
        rsp_valid_next = advance || (rsp_valid_reg && !rsp_ready);
        fwd_next       = fwd_reg;
        if (accept)
        begin
            fwd_next = core_wr;
        end
        else if (advance)
        begin
            fwd_next.en = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            fwd_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            fwd_reg       <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= core_rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `LVC_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_reg && !advance, s1_valid_reg)
    `LVC_ASSERT_IMPLY(a_fwd_live, clk, rst_n, fwd_reg.en, s1_valid_reg)
    `LVC_ASSERT_NEXT(a_rsp_from_advance, clk, rst_n, advance, rsp_valid_reg)

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Cache controller testbench
// Drives read and write accesses through the request channel, predicts each
// response with a model of the exclusive L1 / victim / L2 hierarchy, and
// compares every response field under varied sender and receiver idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import lvc_pkg::*;

    localparam int L1N = 16;
    localparam int VN = 4;
    localparam int SETS = 16;
    localparam int WAYS = 8;
    localparam int CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    l1_victim_l2_cache_controller uut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // cache image
    bit        l1_v [L1N];
    bit [25:0] l1_t [L1N];
    bit [31:0] l1_w [L1N];
    bit [31:0] l1_a [L1N];
    bit        vc_v [VN];
    bit [31:0] vc_a [VN];
    bit [31:0] vc_w [VN];
    int        vc_age [VN];
    bit        l2_v [SETS][WAYS];
    bit [25:0] l2_t [SETS][WAYS];
    bit [31:0] l2_w [SETS][WAYS];
    int        l2_age [SETS][WAYS];
    bit [31:0] read_stats [6];

    rsp_t pending_rsp [$];
    int   errors = 0;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    bit   hold_off = 1'b0;
    int   cycles = 0;

    function automatic bit [3:0] set_of(bit [31:0] a);
        return a[5:2];
    endfunction

    function automatic bit [25:0] tag_of(bit [31:0] a);
        return a[31:6];
    endfunction

    function automatic void l2_place(bit [31:0] a, bit [31:0] w);
        bit [3:0] s;
        s = set_of(a);
        for (int j = 0; j < WAYS; j++)
        begin
            if (l2_age[s][j] == WAYS - 1)
            begin
                l2_v[s][j] = 1'b1;
                l2_t[s][j] = tag_of(a);
                l2_w[s][j] = w;
                for (int k = 0; k < WAYS; k++)
                    l2_age[s][k] = l2_age[s][k] + 1;
                l2_age[s][j] = 0;
                return;
            end
        end
    endfunction

    function automatic void victim_place(bit [31:0] a, bit [31:0] w);
        for (int i = 0; i < VN; i++)
        begin
            if (vc_age[i] == VN - 1)
            begin
                if (vc_v[i])
                    l2_place(vc_a[i], vc_w[i]);
                vc_v[i] = 1'b1;
                vc_a[i] = a;
                vc_w[i] = w;
                for (int k = 0; k < VN; k++)
                    vc_age[k] = vc_age[k] + 1;
                vc_age[i] = 0;
                return;
            end
        end
    endfunction

    function automatic void l1_place(bit [31:0] a, bit [31:0] w);
        bit [3:0] x;
        x = set_of(a);
        if (l1_v[x])
            victim_place(l1_a[x], l1_w[x]);
        l1_v[x] = 1'b1;
        l1_t[x] = tag_of(a);
        l1_w[x] = w;
        l1_a[x] = a;
    endfunction

    function automatic bit victim_remove(bit [31:0] a, output bit [31:0] w);
        w = '0;
        for (int i = 0; i < VN; i++)
        begin
            if (vc_v[i] && vc_a[i] == a)
            begin
                w = vc_w[i];
                for (int k = 0; k < VN; k++)
                    if (vc_age[k] > vc_age[i])
                        vc_age[k] = vc_age[k] - 1;
                vc_age[i] = VN - 1;
                vc_v[i] = 1'b0;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit l2_remove(bit [31:0] a, output bit [31:0] w);
        bit [3:0] s;
        s = set_of(a);
        w = '0;
        for (int j = 0; j < WAYS; j++)
        begin
            if (l2_v[s][j] && l2_t[s][j] == tag_of(a))
            begin
                w = l2_w[s][j];
                for (int k = 0; k < WAYS; k++)
                    if (l2_age[s][k] > l2_age[s][j])
                        l2_age[s][k] = l2_age[s][k] - 1;
                l2_age[s][j] = WAYS - 1;
                l2_v[s][j] = 1'b0;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void hierarchy_clear();
        for (int i = 0; i < L1N; i++)
            l1_v[i] = 1'b0;
        for (int i = 0; i < VN; i++)
        begin
            vc_v[i] = 1'b0;
            vc_age[i] = i;
        end
        for (int s = 0; s < SETS; s++)
            for (int j = 0; j < WAYS; j++)
            begin
                l2_v[s][j] = 1'b0;
                l2_age[s][j] = j;
            end
        for (int k = 0; k < 6; k++)
            read_stats[k] = '0;
    endfunction

    function automatic rsp_t cache_access(req_t r);
        rsp_t o;
        bit [3:0] x;
        bit hit1;
        bit [31:0] w;
        x = set_of(r.address);
        hit1 = l1_v[x] && l1_t[x] == tag_of(r.address);
        if (r.func == FUNC_READ)
        begin
            read_stats[0]++;
            if (hit1)
            begin
                o.served_from = SRC_L1;
                o.read_data = l1_w[x];
            end
            else
            begin
                read_stats[1]++;
                read_stats[2]++;
                if (victim_remove(r.address, w))
                    o.served_from = SRC_VICTIM;
                else
                begin
                    read_stats[3]++;
                    read_stats[4]++;
                    if (l2_remove(r.address, w))
                        o.served_from = SRC_L2;
                    else
                    begin
                        read_stats[5]++;
                        o.served_from = SRC_MEM;
                        w = r.mem_word;
                    end
                end
                l1_place(r.address, w);
                o.read_data = w;
            end
        end
        else
        begin
            o.read_data = r.write_data;
            if (hit1)
            begin
                o.served_from = SRC_L1;
                l1_w[x] = r.write_data;
                l1_a[x] = r.address;
            end
            else if (victim_remove(r.address, w))
            begin
                o.served_from = SRC_VICTIM;
                l1_place(r.address, r.write_data);
            end
            else if (l2_remove(r.address, w))
            begin
                o.served_from = SRC_L2;
                l1_place(r.address, r.write_data);
            end
            else
                o.served_from = SRC_MEM;
        end
        o.l1_accesses = read_stats[0];
        o.l1_misses = read_stats[1];
        o.victim_accesses = read_stats[2];
        o.victim_misses = read_stats[3];
        o.l2_accesses = read_stats[4];
        o.l2_misses = read_stats[5];
        return o;
    endfunction

    task automatic send_access(bit f, bit [31:0] a, bit [31:0] wd, bit [31:0] mw);
        req_t r;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        r.func = f;
        r.address = a;
        r.write_data = wd;
        r.mem_word = mw;
        req <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        pending_rsp.push_back(cache_access(r));
    endtask

    // response check
    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected response %h", rsp);
            end
            else
            begin
                exp_rsp = pending_rsp.pop_front();
                if (rsp !== exp_rsp)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp src %0d data %h cnt %h %h %h %h %h %h",
                            exp_rsp.served_from, exp_rsp.read_data,
                            exp_rsp.l1_accesses, exp_rsp.l1_misses,
                            exp_rsp.victim_accesses, exp_rsp.victim_misses,
                            exp_rsp.l2_accesses, exp_rsp.l2_misses);
                    if (errors <= 10)
                        $display("          got src %0d data %h cnt %h %h %h %h %h %h",
                            rsp.served_from, rsp.read_data,
                            rsp.l1_accesses, rsp.l1_misses,
                            rsp.victim_accesses, rsp.victim_misses,
                            rsp.l2_accesses, rsp.l2_misses);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_off)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic drain();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    // addresses drawn from a small pool so that all levels see hits
    function automatic bit [31:0] pool_address();
        bit [31:0] a;
        a[5:2] = 4'($urandom_range(3));
        a[31:6] = 26'($urandom_range(23)) ^ 26'({$urandom_range(1), 25'h0});
        a[1:0] = 2'($urandom_range(3));
        return a;
    endfunction

    task automatic test_directed();
        send_access(1'b1, 32'h0000_0000, 32'h0, 32'h8000_0000);
        send_access(1'b1, 32'h0000_0000, 32'h0, 32'h0);
        send_access(1'b0, 32'h0000_0003, 32'h7FFF_FFFF, 32'h0);
        send_access(1'b1, 32'h0000_0000, 32'h0, 32'h0);
        send_access(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send_access(1'b1, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        // evict set 0 six times: victim fills then spills into L2
        for (int i = 1; i <= 6; i++)
            send_access(1'b1, 32'(i) << 6, 32'h0, 32'h1111_0000 + i);
        send_access(1'b1, 32'h0000_0040, 32'h0, 32'h0);
        send_access(1'b1, 32'h0000_0000, 32'h0, 32'h0);
        send_access(1'b0, 32'h0000_0080, 32'h5555_AAAA, 32'h0);
        send_access(1'b1, 32'h0000_0080, 32'h0, 32'h0);
        send_access(1'b0, 32'h0000_0140, 32'hAAAA_5555, 32'h0);
        send_access(1'b1, 32'h0000_0001, 32'h0, 32'h0);
        send_access(1'b1, 32'h0000_0002, 32'h0, 32'h0);
        send_access(1'b1, 32'hFFFF_FFC0, 32'h0, 32'h0000_0001);
        send_access(1'b0, 32'h0123_4567, 32'h8000_0000, 32'h0);
        drain();
    endtask

    task automatic test_random(int n);
        bit [31:0] a;
        for (int i = 0; i < n; i++)
        begin
            a = ($urandom_range(9) == 0) ? $urandom : pool_address();
            send_access($urandom_range(3) != 0, a, $urandom, $urandom);
        end
        drain();
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (60) @(posedge clk);
                hold_off = 1'b0;
            end
            test_random(30);
        join
    endtask

    initial
    begin
        hierarchy_clear();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(150);
        send_idle_pct = 60;
        test_random(150);
        send_idle_pct = 0;
        stall_pct = 60;
        test_random(150);
        send_idle_pct = 7;
        stall_pct = 7;
        test_random(150);
        stall_pct = 0;
        send_idle_pct = 0;
        test_backpressure();
        test_random(200);
        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
